// File: src/assert_macros.svh
// Assertion helpers used by the scheduler core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held
`define RGES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define RGES_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/rges_pkg.sv
// ----------------------------------------------------------------------------
// rges_pkg
// Types, constants and helpers of the random gap event scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package rges_pkg;

  localparam int unsigned MAX_BURST_DEF  = 16;
  localparam int unsigned KIND_COUNT_DEF = 5;
  localparam logic [31:0] DEFAULT_SEED   = 32'h1FEF1E5F;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPOCH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEMBERS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_MIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POKE_MIN  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_POKE_MAX  = 3'd7;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] now_time;
    logic [4:0]  max_events;
  } rges_in_t;

  typedef struct packed {
    logic        event_kind_flag;
    logic [31:0] event_time;
    logic [7:0]  member_index;
    logic [2:0]  feed_kind;
    logic [7:0]  text_index;
    logic        last_event;
  } rges_out_t;

  // which random draw is in flight
  typedef enum logic [2:0] {
    DRAW_SIG_INIT  = 3'd0,
    DRAW_POKE_INIT = 3'd1,
    DRAW_MEMBER    = 3'd2,
    DRAW_KIND      = 3'd3,
    DRAW_TEXT      = 3'd4,
    DRAW_SIG_GAP   = 3'd5,
    DRAW_POKE_GAP  = 3'd6
  } rges_draw_t;

  typedef struct packed {
    logic       latch_in;
    logic       load_seed;
    logic       sel_latch;
    logic       gen_step;
    logic       div_start;
    logic       wb;
    logic       emit;
    rges_draw_t draw;
  } rges_cmd_t;

  typedef struct packed {
    logic op;
    logic go;
    logic more;
    logic sig_sel;
    logic div_done;
  } rges_status_t;

  // one xorshift32 step
  function automatic logic [31:0] xs32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage
`default_nettype wire

// File: src/random_gap_event_scheduler_core.sv
// A restart makes 2 draws and gives no result. A tick makes its draws on
// the serial modulo unit: a signal event takes 4 draws (member, kind, text,
// gap), a poke 2 (member, gap). One item at a time; no input is taken while
// a result waits. Synchronous active-low reset restores register defaults,
// the default generator seed and zero deadlines.
`default_nettype none
module random_gap_event_scheduler_core #(
  parameter int unsigned MAX_BURST  = rges_pkg::MAX_BURST_DEF,
  parameter int unsigned KIND_COUNT = rges_pkg::KIND_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire rges_pkg::rges_in_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output rges_pkg::rges_out_t                  out_data,
  input  wire logic                            cfg_we,
  input  wire logic [rges_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rges_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rges_pkg::*;
`include "assert_macros.svh"

  rges_cmd_t    cmd;
  rges_status_t status;

  rges_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rges_datapath #(.MAX_BURST(MAX_BURST), .KIND_COUNT(KIND_COUNT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  // checks
  `RGES_ASSERT(a_no_take_while_pending, out_valid |-> in_stall, "input taken with result pending")
  `RGES_ASSERT(a_emit_shows_beat, cmd.emit |=> out_valid, "loaded result not shown")
  `RGES_ASSERT(a_draw_after_gen, cmd.gen_step |=> cmd.div_start, "draw did not start modulo")
endmodule
`default_nettype wire

// File: src/rges_mod_unit.sv
// ----------------------------------------------------------------------------
// rges_mod_unit
// Serial restoring modulo unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rges_mod_unit #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      rem
);
  localparam int unsigned CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  num_r, num_nxt;
  logic [W-1:0]  den_r, den_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    sh;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    sh       = {rem_r, num_r[W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W - 1);
      rem_nxt  = '0;
      num_nxt  = dividend;
      den_nxt  = divisor;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (sh >= {1'b0, den_r}) rem_nxt = W'(sh - {1'b0, den_r});
      else rem_nxt = sh[W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

// File: src/rges_ctrl.sv
// ----------------------------------------------------------------------------
// rges_ctrl
// Sequencer: restart, per-event draws, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module rges_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire rges_pkg::rges_status_t status,
  output rges_pkg::rges_cmd_t        cmd
);
  import rges_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SEED   = 8'b0000_0010,
    ST_CHECK  = 8'b0000_0100,
    ST_GEN    = 8'b0000_1000,
    ST_START  = 8'b0001_0000,
    ST_WAIT   = 8'b0010_0000,
    ST_DECIDE = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  rges_draw_t draw_r, draw_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    draw_nxt  = draw_r;
    cmd       = '0;
    cmd.draw  = draw_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      ST_SEED: begin
        cmd.load_seed = 1'b1;
        draw_nxt      = DRAW_SIG_INIT;
        state_nxt     = ST_GEN;
      end
      ST_CHECK: begin
        if (status.op == OP_RESTART) begin
          state_nxt = ST_SEED;
        end else if (status.go) begin
          cmd.sel_latch = 1'b1;
          draw_nxt      = DRAW_MEMBER;
          state_nxt     = ST_GEN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_GEN: begin
        cmd.gen_step = 1'b1;
        state_nxt    = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.div_done) begin
          cmd.wb    = 1'b1;
          state_nxt = ST_GEN;
          case (draw_r)
            DRAW_SIG_INIT:  draw_nxt = DRAW_POKE_INIT;
            DRAW_POKE_INIT: state_nxt = ST_IDLE;
            DRAW_MEMBER:    draw_nxt = status.sig_sel ? DRAW_KIND : DRAW_POKE_GAP;
            DRAW_KIND:      draw_nxt = DRAW_TEXT;
            DRAW_TEXT:      draw_nxt = DRAW_SIG_GAP;
            default:        state_nxt = ST_DECIDE;
          endcase
        end
      end
      ST_DECIDE: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_stall) state_nxt = status.more ? ST_CHECK : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      draw_r  <= DRAW_SIG_INIT;
    end else begin
      state_r <= state_nxt;
      draw_r  <= draw_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
endmodule
`default_nettype wire

// File: src/rges_datapath.sv
// ----------------------------------------------------------------------------
// rges_datapath
// Config registers, generator, deadlines, modulo unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module rges_datapath #(
  parameter int unsigned MAX_BURST  = rges_pkg::MAX_BURST_DEF,
  parameter int unsigned KIND_COUNT = rges_pkg::KIND_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire rges_pkg::rges_in_t                  in_data,
  output rges_pkg::rges_out_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [rges_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rges_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire rges_pkg::rges_cmd_t                 cmd,
  output rges_pkg::rges_status_t                   status
);
  import rges_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BURST + 1);

  logic [31:0] seed_r, epoch_r;
  logic [7:0]  members_r, texts_r;
  logic [23:0] sig_min_r, sig_max_r, poke_min_r, poke_max_r;
  logic [31:0] gen_r, sig_dl_r, poke_dl_r;
  logic        op_r, sel_r;
  logic [31:0] now_r, time_r;
  logic [CNT_W-1:0] limit_r, count_r;
  logic [7:0]  member_r, text_r;
  logic [2:0]  kind_r;
  rges_out_t   out_r;

  logic [31:0] lim_wide;
  logic [23:0] lo, hi;
  logic [31:0] span, divisor, rem, gap;
  logic        div_done;
  logic        sig_first, due;
  logic [31:0] due_dl;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= '0;
      epoch_r    <= '0;
      members_r  <= 8'd1;
      texts_r    <= 8'd8;
      sig_min_r  <= 24'd1000;
      sig_max_r  <= 24'd5000;
      poke_min_r <= 24'd3000;
      poke_max_r <= 24'd9000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED:     seed_r     <= cfg_data;
        REG_EPOCH:    epoch_r    <= cfg_data;
        REG_MEMBERS:  members_r  <= cfg_data[7:0];
        REG_TEXTS:    texts_r    <= cfg_data[7:0];
        REG_SIG_MIN:  sig_min_r  <= cfg_data[23:0];
        REG_SIG_MAX:  sig_max_r  <= cfg_data[23:0];
        REG_POKE_MIN: poke_min_r <= cfg_data[23:0];
        REG_POKE_MAX: poke_max_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // effective event cap
  always_comb begin
    lim_wide = (32'(in_data.max_events) > 32'(MAX_BURST)) ? 32'(MAX_BURST)
                                                          : 32'(in_data.max_events);
    if (members_r == '0) lim_wide = '0;
  end

  // divisor selection per draw
  always_comb begin
    lo = sig_min_r;
    hi = sig_max_r;
    if (cmd.draw == DRAW_POKE_INIT || cmd.draw == DRAW_POKE_GAP) begin
      lo = poke_min_r;
      hi = poke_max_r;
    end
    span = (hi < lo) ? 32'd1 : 32'(hi - lo) + 32'd1;
    case (cmd.draw)
      DRAW_MEMBER: divisor = 32'(members_r);
      DRAW_KIND:   divisor = 32'(KIND_COUNT);
      DRAW_TEXT:   divisor = (texts_r == '0) ? 32'd1 : 32'(texts_r);
      default:     divisor = span;
    endcase
    gap = 32'(lo) + rem;
  end

  rges_mod_unit #(.W(32)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (gen_r),
    .divisor  (divisor),
    .done     (div_done),
    .rem      (rem)
  );

  // wrap-safe ordering and due test
  always_comb begin
    sig_first = ~(poke_dl_r - sig_dl_r) >> 31 != 32'd0;
    due_dl    = sig_first ? sig_dl_r : poke_dl_r;
    due       = ((now_r - due_dl) & 32'h8000_0000) == 32'd0;
    status.op       = op_r;
    status.go       = (count_r < limit_r) && due;
    status.more     = (32'(count_r) < 32'(limit_r)) && due;
    status.sig_sel  = sel_r;
    status.div_done = div_done;
  end

  // generator, deadlines and event fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r     <= DEFAULT_SEED;
      sig_dl_r  <= '0;
      poke_dl_r <= '0;
      op_r      <= OP_TICK;
      count_r   <= '0;
      limit_r   <= '0;
    end else begin
      if (cmd.latch_in) begin
        op_r    <= in_data.op;
        limit_r <= lim_wide[CNT_W-1:0];
        count_r <= '0;
      end
      if (cmd.load_seed) gen_r <= (seed_r != '0) ? seed_r : DEFAULT_SEED;
      else if (cmd.gen_step) gen_r <= xs32(gen_r);
      if (cmd.wb) begin
        case (cmd.draw)
          DRAW_SIG_INIT:  sig_dl_r  <= epoch_r + gap;
          DRAW_POKE_INIT: poke_dl_r <= epoch_r + gap;
          DRAW_SIG_GAP:   sig_dl_r  <= sig_dl_r + gap;
          DRAW_POKE_GAP:  poke_dl_r <= poke_dl_r + gap;
          default: ;
        endcase
      end
      if (cmd.emit) count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) now_r <= in_data.now_time;
    if (cmd.sel_latch) begin
      sel_r  <= sig_first;
      time_r <= due_dl;
    end
    if (cmd.wb) begin
      case (cmd.draw)
        DRAW_MEMBER: member_r <= rem[7:0];
        DRAW_KIND:   kind_r   <= rem[2:0];
        DRAW_TEXT:   text_r   <= (texts_r == '0) ? 8'd0 : rem[7:0];
        default: ;
      endcase
    end
    // result register; deadlines are final here, count not yet bumped
    if (cmd.emit) begin
      out_r.event_kind_flag <= ~sel_r;
      out_r.event_time      <= time_r;
      out_r.member_index    <= member_r;
      out_r.feed_kind       <= sel_r ? kind_r : 3'd0;
      out_r.text_index      <= sel_r ? text_r : 8'd0;
      out_r.last_event      <= !((32'(count_r) + 32'd1 < 32'(limit_r)) && due);
    end
  end

  assign out_data = out_r;
endmodule
`default_nettype wire
